// File: sv/osm_pkg.sv
// package: types, constants and operation codes for the order statistic multiset
package osm_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 30;
    localparam int OPERAND_W      = 30;
    localparam int SIZE_W         = 11;
    localparam int KIND_W         = 3;

    localparam logic [KIND_W-1:0] OP_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] OP_ERASE  = 3'd1;
    localparam logic [KIND_W-1:0] OP_KTH    = 3'd2;
    localparam logic [KIND_W-1:0] OP_RANK   = 3'd3;
    localparam logic [KIND_W-1:0] OP_COUNT  = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [OPERAND_W-1:0] operand;
    } req_t;

    typedef struct packed {
        logic [OPERAND_W-1:0] answer;
        logic                 ok;
        logic [SIZE_W-1:0]    size;
    } resp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic srch_init; // start a bound search
        logic srch_incl; // inclusive bound
        logic srch_rd;   // issue probe read
        logic srch_upd;  // consume probe data
        logic save_lo;   // keep first bound
        logic sh_init;   // start shift sweep
        logic sh_rd;     // issue shift read
        logic sh_wr;     // write shifted entry
        logic put_x;     // write new value at position
        logic kth_rd;    // read entry k
        logic inc;
        logic dec;
        logic fin;       // build response
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic srch_done;
        logic full;
        logic found;     // entry at bound equals x
        logic sh_done;
        logic kth_ok;
    } stat_t;

endpackage

// File: sv/order_statistic_multiset_top.sv
// top level: sorted multiset with insert, erase, kth, rank and count
// Holds up to CAPACITY values in one ram kept in ascending order. One beat is taken at a time
// and answered with one result beat. Insert, rank, count and erase run a binary search, each
// probe a read state then an update state (count searches twice). Insert and erase then shift
// the tail one entry at a time, a read state then a write state per entry, through the ram.
// Kth reads one entry. No clearing pass.
module order_statistic_multiset_top #(
    parameter int CAPACITY   = osm_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = osm_pkg::VALUE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  osm_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output osm_pkg::resp_t m_data
);
    osm_pkg::cmd_t  cmd;
    osm_pkg::stat_t stat;
    osm_pkg::resp_t resp;
    logic           fail;

    osm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .s_kind (s_data.kind),
        .stat   (stat),
        .cmd    (cmd),
        .fail   (fail)
    );

    osm_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (s_data),
        .cmd    (cmd),
        .stat   (stat),
        .resp   (resp)
    );

    always_comb begin
        m_data = resp;
        if (fail) begin
            m_data.ok     = 1'b0;
            m_data.answer = '0;
        end
    end
endmodule

// File: sv/osm_ram.sv
// generic single port write, single port read ram with registered read
module osm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/osm_datapath.sv
// datapath: sorted store, binary search, shift sweep and result formatting
module osm_datapath #(
    parameter int CAPACITY   = osm_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = osm_pkg::VALUE_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  osm_pkg::req_t  req,
    input  osm_pkg::cmd_t  cmd,
    output osm_pkg::stat_t stat,
    output osm_pkg::resp_t resp
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [osm_pkg::KIND_W-1:0]    kind_reg;
    logic [osm_pkg::OPERAND_W-1:0] opnd_reg;
    logic [VALUE_BITS-1:0]         x;
    logic [CW-1:0] cnt_reg, lo_reg, hi_reg, lo0_reg, sh_reg;
    logic          incl_reg;
    logic [CW-1:0] mid;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;
    logic          go_right;
    logic          erase_dir;

    assign x = VALUE_BITS'(opnd_reg);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = incl_reg ? (rdata <= x) : (rdata < x);
    assign erase_dir = (kind_reg == osm_pkg::OP_ERASE);

    always_comb begin
        raddr = AW'(mid);
        if (cmd.sh_rd) begin
            raddr = erase_dir ? AW'(sh_reg + CW'(1)) : AW'(sh_reg - CW'(1));
        end else if (cmd.kth_rd) begin
            raddr = AW'(opnd_reg);
        end
        we    = cmd.sh_wr | cmd.put_x;
        waddr = AW'(sh_reg);
        wdata = rdata;
        if (cmd.put_x) begin
            waddr = AW'(lo_reg);
            wdata = x;
        end
    end

    osm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign stat.srch_done = (lo_reg == hi_reg);
    assign stat.full      = (cnt_reg == CW'(CAPACITY));
    assign stat.found     = (lo_reg < cnt_reg) && (rdata == x);
    assign stat.sh_done   = erase_dir ? (sh_reg + CW'(1) >= cnt_reg) : (sh_reg == lo_reg);
    assign stat.kth_ok    = ({2'b0, opnd_reg} < (osm_pkg::OPERAND_W+2)'(cnt_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.inc) begin
            cnt_reg <= cnt_reg + CW'(1);
        end else if (cmd.dec) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= req.kind;
            opnd_reg <= req.operand;
        end
        if (cmd.srch_init) begin
            lo_reg   <= '0;
            hi_reg   <= cnt_reg;
            incl_reg <= cmd.srch_incl;
        end else if (cmd.srch_upd) begin
            if (go_right) begin
                lo_reg <= mid + CW'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.save_lo) begin
            lo0_reg <= lo_reg;
        end
        if (cmd.sh_init) begin
            sh_reg <= erase_dir ? lo_reg : cnt_reg;
        end else if (cmd.sh_wr) begin
            sh_reg <= erase_dir ? sh_reg + CW'(1) : sh_reg - CW'(1);
        end
        if (cmd.fin) begin
            resp.size <= osm_pkg::SIZE_W'(cnt_reg);
            case (kind_reg)
                osm_pkg::OP_INSERT, osm_pkg::OP_ERASE: begin
                    resp.ok     <= 1'b1;
                    resp.answer <= '0;
                end
                osm_pkg::OP_KTH: begin
                    resp.ok     <= 1'b1;
                    resp.answer <= osm_pkg::OPERAND_W'(rdata);
                end
                osm_pkg::OP_RANK: begin
                    resp.ok     <= 1'b1;
                    resp.answer <= osm_pkg::OPERAND_W'(lo_reg);
                end
                osm_pkg::OP_COUNT: begin
                    resp.ok     <= 1'b1;
                    resp.answer <= osm_pkg::OPERAND_W'(lo_reg - lo0_reg);
                end
                default: begin
                    resp.ok     <= 1'b0;
                    resp.answer <= '0;
                end
            endcase
        end else if (cmd.load) begin
            resp.ok <= 1'b0;
        end
    end
endmodule

// File: sv/osm_ctrl.sv
// controller: sequences each operation over the datapath
module osm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  logic [osm_pkg::KIND_W-1:0] s_kind,
    input  osm_pkg::stat_t stat,
    output osm_pkg::cmd_t  cmd,
    output logic           fail
);
    typedef enum logic [3:0] {
        IDLE, DISPATCH, S_RD, S_UPD, SH_RD, SH_WR, PUT, DEL,
        KTH_RD, KTH_WAIT, FIN, OUT
    } state_t;

    state_t state_reg, state_next;
    logic [osm_pkg::KIND_W-1:0] kind_reg;
    logic pass_reg, pass_next;  // 0 first bound, 1 second bound of count
    logic fail_reg, fail_next;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = (state_reg == OUT);
    assign fail    = fail_reg;

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        fail_next  = fail_reg;
        cmd = '0;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    fail_next  = 1'b0;
                    pass_next  = 1'b0;
                    state_next = DISPATCH;
                end
            end
            DISPATCH: begin
                case (kind_reg)
                    osm_pkg::OP_INSERT: begin
                        if (stat.full) begin
                            fail_next  = 1'b1;
                            state_next = FIN;
                        end else begin
                            cmd.srch_init = 1'b1;
                            cmd.srch_incl = 1'b1;
                            state_next    = S_RD;
                        end
                    end
                    osm_pkg::OP_ERASE, osm_pkg::OP_RANK, osm_pkg::OP_COUNT: begin
                        cmd.srch_init = 1'b1;
                        state_next    = S_RD;
                    end
                    osm_pkg::OP_KTH: state_next = KTH_RD;
                    default: state_next = FIN;
                endcase
            end
            S_RD: begin
                if (stat.srch_done) begin
                    case (kind_reg)
                        osm_pkg::OP_INSERT: begin
                            cmd.sh_init = 1'b1;
                            state_next  = SH_RD;
                        end
                        osm_pkg::OP_ERASE: begin
                            cmd.kth_rd = 1'b0;
                            state_next = DEL;
                        end
                        osm_pkg::OP_COUNT: begin
                            if (!pass_reg) begin
                                cmd.save_lo   = 1'b1;
                                cmd.srch_init = 1'b1;
                                cmd.srch_incl = 1'b1;
                                pass_next     = 1'b1;
                            end else begin
                                state_next = FIN;
                            end
                        end
                        default: state_next = FIN;
                    endcase
                end else begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD: begin
                cmd.srch_upd = 1'b1;
                state_next   = S_RD;
            end
            DEL: begin
                if (stat.found) begin
                    cmd.sh_init = 1'b1;
                    state_next  = SH_RD;
                end else begin
                    fail_next  = 1'b1;
                    state_next = FIN;
                end
            end
            SH_RD: begin
                if (stat.sh_done) begin
                    state_next = PUT;
                end else begin
                    cmd.sh_rd  = 1'b1;
                    state_next = SH_WR;
                end
            end
            SH_WR: begin
                cmd.sh_wr  = 1'b1;
                state_next = SH_RD;
            end
            PUT: begin
                if (kind_reg == osm_pkg::OP_INSERT) begin
                    cmd.put_x = 1'b1;
                    cmd.inc   = 1'b1;
                end else begin
                    cmd.dec = 1'b1;
                end
                state_next = FIN;
            end
            KTH_RD: begin
                cmd.kth_rd = 1'b1;
                if (!stat.kth_ok) begin
                    fail_next = 1'b1;
                end
                state_next = KTH_WAIT;
            end
            KTH_WAIT: begin
                cmd.kth_rd = 1'b1;
                state_next = FIN;
            end
            FIN: begin
                cmd.fin    = 1'b1;
                state_next = OUT;
            end
            OUT: begin
                if (m_ready) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            pass_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            kind_reg  <= osm_pkg::OP_INSERT;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            fail_reg  <= fail_next;
            if (cmd.load) begin
                kind_reg <= s_kind;
            end
        end
    end
endmodule

// File: sim/tb_order_statistic_multiset_top.sv
// testbench: sorted multiset checked against a queue-based predictor with random idling
`timescale 1ns / 1ps

module tb_order_statistic_multiset_top;

    localparam int CAP = osm_pkg::CAPACITY_DEF;
    localparam int N_RANDOM = 730;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    osm_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    osm_pkg::resp_t m_data;

    order_statistic_multiset_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    typedef struct {
        logic [osm_pkg::KIND_W-1:0]    kind;
        logic [osm_pkg::OPERAND_W-1:0] operand;
        bit                            typed;
        osm_pkg::resp_t                resp;
    } row_t;

    logic [osm_pkg::OPERAND_W-1:0] sorted_vals[$];
    osm_pkg::resp_t pending_resp[$];
    int errors = 0;
    bit quiet = 0;
    bit drain_stall = 0;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("tb_order_statistic_multiset_top NOT OK");
        $finish;
    end

    function automatic int lower_bound(logic [osm_pkg::OPERAND_W-1:0] x, bit incl);
        int lo, hi, mid;
        lo = 0;
        hi = sorted_vals.size();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (incl ? (sorted_vals[mid] <= x) : (sorted_vals[mid] < x)) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic osm_pkg::resp_t apply_op(osm_pkg::req_t r);
        osm_pkg::resp_t o;
        int p;
        o = '0;
        case (r.kind)
            osm_pkg::OP_INSERT: if (sorted_vals.size() < CAP) begin
                p = lower_bound(r.operand, 1);
                sorted_vals.insert(p, r.operand);
                o.ok = 1;
            end
            osm_pkg::OP_ERASE: begin
                p = lower_bound(r.operand, 0);
                if (p < sorted_vals.size() && sorted_vals[p] == r.operand) begin
                    sorted_vals.delete(p);
                    o.ok = 1;
                end
            end
            osm_pkg::OP_KTH: if (r.operand < sorted_vals.size()) begin
                o.answer = sorted_vals[r.operand];
                o.ok = 1;
            end
            osm_pkg::OP_RANK: begin
                o.answer = osm_pkg::OPERAND_W'(lower_bound(r.operand, 0));
                o.ok = 1;
            end
            osm_pkg::OP_COUNT: begin
                o.answer = osm_pkg::OPERAND_W'(lower_bound(r.operand, 1)
                                               - lower_bound(r.operand, 0));
                o.ok = 1;
            end
            default: ;
        endcase
        o.size = osm_pkg::SIZE_W'(sorted_vals.size());
        return o;
    endfunction

    // result side: sample at rising edge, stall at falling edge
    always @(posedge aclk) begin
        osm_pkg::resp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_resp.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $time, m_data);
                errors++;
            end else begin
                e = pending_resp.pop_front();
                if (m_data.answer !== e.answer || m_data.ok !== e.ok || m_data.size !== e.size) begin
                    $display("%0t mismatch: expected ans=%0d ok=%0d size=%0d, actual ans=%0d ok=%0d size=%0d",
                             $time, e.answer, e.ok, e.size, m_data.answer, m_data.ok, m_data.size);
                    errors++;
                end
            end
        end
    end

    initial begin
        int gap;
        m_ready = 0;
        gap = 0;
        forever begin
            @(negedge aclk);
            if (gap > 0) begin
                gap--;
                m_ready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic send_beat(osm_pkg::req_t r, bit typed, osm_pkg::resp_t t);
        osm_pkg::resp_t e;
        int g;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            g = $urandom_range(1, 4);
            repeat (g) @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        e = apply_op(r);
        if (typed && e !== t) begin
            $display("%0t table row: expected %h, actual %h", $time, t, e);
            errors++;
        end
        pending_resp.push_back(e);
    endtask

    // hold off until the block drains
    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (pending_resp.size() != 0) @(negedge aclk);
    endtask

    function automatic osm_pkg::resp_t mk(logic [osm_pkg::OPERAND_W-1:0] a, logic k, int sz);
        osm_pkg::resp_t o;
        o.answer = a;
        o.ok = k;
        o.size = osm_pkg::SIZE_W'(sz);
        return o;
    endfunction

    function automatic logic [osm_pkg::OPERAND_W-1:0] pick_value();
        if (sorted_vals.size() > 0 && $urandom_range(0, 2) == 0)
            return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        case ($urandom_range(0, 3))
            0: return osm_pkg::OPERAND_W'($urandom_range(0, 15));
            1: return {osm_pkg::OPERAND_W{1'b1}} - osm_pkg::OPERAND_W'($urandom_range(0, 3));
            default: return osm_pkg::OPERAND_W'($urandom());
        endcase
    endfunction

    initial begin
        row_t dir[$];
        osm_pkg::req_t r;
        int limit;
        localparam logic [osm_pkg::OPERAND_W-1:0] TOP = {osm_pkg::OPERAND_W{1'b1}};
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        dir = '{
            '{osm_pkg::OP_KTH, 0, 1, mk(0, 0, 0)},
            '{osm_pkg::OP_ERASE, 5, 1, mk(0, 0, 0)},
            '{osm_pkg::OP_RANK, TOP, 1, mk(0, 1, 0)},
            '{osm_pkg::OP_COUNT, 0, 1, mk(0, 1, 0)},
            '{osm_pkg::OP_INSERT, TOP, 1, mk(0, 1, 1)},
            '{osm_pkg::OP_INSERT, 0, 1, mk(0, 1, 2)},
            '{osm_pkg::OP_INSERT, TOP, 1, mk(0, 1, 3)},
            '{osm_pkg::OP_KTH, 0, 1, mk(0, 1, 3)},
            '{osm_pkg::OP_KTH, 2, 1, mk(TOP, 1, 3)},
            '{osm_pkg::OP_KTH, 3, 1, mk(0, 0, 3)},
            '{osm_pkg::OP_KTH, TOP, 1, mk(0, 0, 3)},
            '{osm_pkg::OP_COUNT, TOP, 1, mk(2, 1, 3)},
            '{osm_pkg::OP_RANK, TOP, 1, mk(1, 1, 3)},
            '{osm_pkg::OP_INSERT, 30'h2aaa_aaaa, 0, '0},
            '{osm_pkg::OP_INSERT, 30'h1555_5555, 0, '0},
            '{osm_pkg::OP_RANK, 30'h2000_0000, 0, '0},
            '{osm_pkg::OP_ERASE, TOP, 1, mk(0, 1, 4)},
            '{osm_pkg::OP_ERASE, 30'h1555_5554, 1, mk(0, 0, 4)},
            '{3'd5, TOP, 1, mk(0, 0, 4)},
            '{3'd6, 0, 1, mk(0, 0, 4)},
            '{3'd7, 30'h1234_5678, 1, mk(0, 0, 4)},
            '{osm_pkg::OP_COUNT, TOP, 1, mk(1, 1, 4)}
        };
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        foreach (dir[i]) begin
            r.kind = dir[i].kind;
            r.operand = dir[i].operand;
            send_beat(r, dir[i].typed, dir[i].resp);
        end
        drain();
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 80) quiet = 1;
            if (n >= 150 && n < 330 && n % 2 == 0) r.kind = osm_pkg::OP_INSERT;
            else if (n >= 330 && n < 350) r.kind = osm_pkg::OP_INSERT;
            else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5: r.kind = osm_pkg::OP_INSERT;
                    6, 7, 8, 9: r.kind = osm_pkg::OP_ERASE;
                    10, 11, 12: r.kind = osm_pkg::OP_KTH;
                    13, 14, 15: r.kind = osm_pkg::OP_RANK;
                    16, 17, 18: r.kind = osm_pkg::OP_COUNT;
                    default: r.kind = osm_pkg::KIND_W'(5 + $urandom_range(0, 2));
                endcase
            end
            if (r.kind == osm_pkg::OP_KTH) begin
                if ($urandom_range(0, 7) == 0) r.operand = osm_pkg::OPERAND_W'($urandom());
                else r.operand = osm_pkg::OPERAND_W'($urandom_range(0, sorted_vals.size() + 1));
            end else begin
                r.operand = pick_value();
            end
            send_beat(r, 0, '0);
            if (n == 400)
                drain();
        end
        r.kind = osm_pkg::OP_INSERT;
        r.operand = 7;
        send_beat(r, 0, '0);
        r.kind = osm_pkg::OP_KTH;
        r.operand = osm_pkg::OPERAND_W'(CAP - 1);
        send_beat(r, 0, '0);
        r.operand = osm_pkg::OPERAND_W'(CAP);
        send_beat(r, 0, '0);
        r.kind = osm_pkg::OP_ERASE;
        r.operand = (sorted_vals.size() > 0) ? sorted_vals[0] : '0;
        send_beat(r, 0, '0);
        @(negedge aclk);
        s_valid <= 0;
        limit = 0;
        while (pending_resp.size() != 0 && limit < 200000) begin
            @(negedge aclk);
            limit++;
        end
        repeat (4200) @(negedge aclk);
        if (errors == 0 && pending_resp.size() == 0) begin
            $display("tb_order_statistic_multiset_top OK");
        end else begin
            $display("tb_order_statistic_multiset_top NOT OK");
        end
        $finish;
    end
endmodule

// File: order_statistic_multiset_top.f
sv/osm_pkg.sv
sv/osm_ram.sv
sv/osm_datapath.sv
sv/osm_ctrl.sv
sv/order_statistic_multiset_top.sv
sim/tb_order_statistic_multiset_top.sv
